// File: hw/rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared constants for the particle cell binning pipeline.
// ----------------------------------------------------------------------------
package pcb_pkg;

   localparam int POS_BITS       = 32;
   localparam int COEF_BITS      = 21;
   localparam int FRAC_SHIFT     = 36;
   localparam int ROW_BITS       = 63;
   localparam int CELL_OUT_BITS  = 10;
   localparam int RANK_OUT_BITS  = 10;
   localparam int IDX_BITS       = 20;
   localparam int CSR_ADDR_BITS  = 3;

   localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ROW_A    = 3'd0,
      CSR_ROW_B    = 3'd1,
      CSR_ROW_C    = 3'd2,
      CSR_GLOBAL   = 3'd3,
      CSR_LOCAL    = 3'd4,
      CSR_DOMAINS  = 3'd5
   } csr_addr_type;

endpackage

// File: hw/rtl/pcb_cell_stage.sv
// ----------------------------------------------------------------------------
// pcb_cell_stage
// Maps a position through the inverse box matrix and bins it per axis.
// ----------------------------------------------------------------------------
module pcb_cell_stage #(
   parameter int CB = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [pcb_pkg::POS_BITS-1:0]    pos_x,
   input  logic signed [pcb_pkg::POS_BITS-1:0]    pos_y,
   input  logic signed [pcb_pkg::POS_BITS-1:0]    pos_z,
   input  logic [2:0][pcb_pkg::ROW_BITS-1:0]      rows,
   input  logic [3*CB-1:0]                        gcounts,
   output logic                                   out_valid,
   output logic [2:0][CB-1:0]                     cell_o
);

   localparam int PW = pcb_pkg::POS_BITS + pcb_pkg::COEF_BITS;
   localparam int SW = PW + 2;
   localparam int MW = pcb_pkg::FRAC_SHIFT + CB;

   logic [3:0]                     v_ff;
   logic signed [PW-1:0]           prod_ff [3][3];
   logic signed [PW-1:0]           prod_in [3][3];
   logic signed [SW-1:0]           sum_ff  [3];
   logic signed [SW-1:0]           sum_in  [3];
   logic [2:0]                     zero_ff, zero_in, high_ff, high_in;
   logic [MW-1:0]                  scl_ff  [3];
   logic [MW-1:0]                  scl_in  [3];
   logic [2:0][CB-1:0]             cnt_ff, cnt_in, cell_ff, cell_in;
   logic signed [pcb_pkg::POS_BITS-1:0] pos [3];

   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign pos[2] = pos_z;

   always_comb begin
      logic signed [pcb_pkg::COEF_BITS-1:0] coef;
      logic [CB-1:0] v;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            coef = signed'(rows[a][k*pcb_pkg::COEF_BITS +: pcb_pkg::COEF_BITS]);
            prod_in[a][k] = PW'(pos[k]) * PW'(coef);
         end
         sum_in[a] = SW'(prod_ff[a][0]) + SW'(prod_ff[a][1]) + SW'(prod_ff[a][2]);
         cnt_in[a] = gcounts[a*CB +: CB];
         zero_in[a] = (cnt_in[a] == '0) || sum_ff[a][SW-1] || (sum_ff[a] == '0);
         high_in[a] = (sum_ff[a][SW-2:pcb_pkg::FRAC_SHIFT] != '0);
         scl_in[a] = MW'(sum_ff[a][pcb_pkg::FRAC_SHIFT-1:0]) * MW'(cnt_in[a]);
         v = scl_ff[a][pcb_pkg::FRAC_SHIFT +: CB];
         if (zero_ff[a]) begin
            cell_in[a] = '0;
         end else if (high_ff[a] || (v >= cnt_ff[a])) begin
            cell_in[a] = cnt_ff[a] - CB'(1);
         end else begin
            cell_in[a] = v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         zero_ff <= zero_in;
         high_ff <= high_in;
         scl_ff  <= scl_in;
         cnt_ff  <= cnt_in;
         cell_ff <= cell_in;
      end
   end

   assign out_valid = v_ff[3];
   assign cell_o    = cell_ff;

endmodule

// File: hw/rtl/pcb_divider.sv
// ----------------------------------------------------------------------------
// pcb_divider
// Pipelined restoring divider, one quotient bit per stage on each axis.
// ----------------------------------------------------------------------------
module pcb_divider #(
   parameter int CB = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [2:0][CB-1:0] cell_i,
   input  logic [3*CB-1:0]    lcounts,
   output logic               out_valid,
   output logic [2:0][CB-1:0] cell_o,
   output logic [2:0][CB-1:0] dom,
   output logic [2:0][CB-1:0] loc
);

   logic [CB:1]                v_ff;
   logic [2:0][CB-1:0]         rem_ff [1:CB];
   logic [2:0][CB-1:0]         quo_ff [1:CB];
   logic [2:0][CB-1:0]         cel_ff [1:CB];

   genvar s;
   generate
      for (s = 0; s < CB; s++) begin : g_stage
         logic               vs;
         logic [2:0][CB-1:0] rs, qs, cs, rn, qn;
         if (s == 0) begin : g_first
            assign vs = in_valid;
            assign rs = '0;
            assign qs = '0;
            assign cs = cell_i;
         end else begin : g_next
            assign vs = v_ff[s];
            assign rs = rem_ff[s];
            assign qs = quo_ff[s];
            assign cs = cel_ff[s];
         end
         always_comb begin
            logic [CB:0]   trial;
            logic [CB-1:0] d;
            for (int a = 0; a < 3; a++) begin
               d = lcounts[a*CB +: CB];
               trial = {rs[a], cs[a][CB-1-s]};
               if (trial >= {1'b0, d}) begin
                  rn[a] = CB'(trial - {1'b0, d});
                  qn[a] = {qs[a][CB-2:0], 1'b1};
               end else begin
                  rn[a] = trial[CB-1:0];
                  qn[a] = {qs[a][CB-2:0], 1'b0};
               end
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s+1] <= 1'b0;
            end else if (en) begin
               v_ff[s+1] <= vs;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= rn;
               quo_ff[s+1] <= qn;
               cel_ff[s+1] <= cs;
            end
         end
      end
   endgenerate

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (lcounts[a*CB +: CB] == '0) begin
            dom[a] = '0;
            loc[a] = cel_ff[CB][a];
         end else begin
            dom[a] = quo_ff[CB][a];
            loc[a] = rem_ff[CB][a];
         end
      end
   end

   assign out_valid = v_ff[CB];
   assign cell_o    = cel_ff[CB];

endmodule

// File: hw/rtl/pcb_index_stage.sv
// ----------------------------------------------------------------------------
// pcb_index_stage
// Forms domain rank and local cell index, with overflow and saturation.
// ----------------------------------------------------------------------------
module pcb_index_stage #(
   parameter int CB          = 10,
   parameter int MAX_DOMAINS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [2:0][CB-1:0]                    cell_i,
   input  logic [2:0][CB-1:0]                    dom,
   input  logic [2:0][CB-1:0]                    loc,
   input  logic [3*CB-1:0]                       lcounts,
   input  logic [3*CB-1:0]                       dcounts,
   output logic                                  out_valid,
   output logic [2:0][pcb_pkg::CELL_OUT_BITS-1:0] cell_o,
   output logic [pcb_pkg::RANK_OUT_BITS-1:0]     rank,
   output logic [pcb_pkg::IDX_BITS-1:0]          idx,
   output logic                                  err
);

   localparam int W2 = 2 * CB;
   localparam int W3 = 3 * CB;

   logic [3:0]                  v_ff;
   logic [2:0][CB-1:0]          c1_ff, c2_ff, c3_ff;
   logic [2:0]                  e_ff;
   logic [CB-1:0]               d0_1_ff, d0_2_ff, d0_3_ff, d1_1_ff, l0_1_ff, l0_2_ff, l2_1_ff;
   logic [W2-1:0]               m1_ff, ynx_1_ff, ynx_2_ff, nxy_ff;
   logic [W2:0]                 t_ff;
   logic [W3-1:0]               zp_ff;
   logic [W3:0]                 rx_ff, is_ff;
   logic [W3+1:0]               rsum;
   logic                        over;
   logic [pcb_pkg::RANK_OUT_BITS-1:0] rank_ff;
   logic [pcb_pkg::IDX_BITS-1:0]      idx_ff;
   logic                        err_ff;
   logic [CB-1:0]               nx, ny, nz, dx, dy;

   assign nx = lcounts[0 +: CB];
   assign ny = lcounts[CB +: CB];
   assign nz = lcounts[2*CB +: CB];
   assign dx = dcounts[0 +: CB];
   assign dy = dcounts[CB +: CB];

   assign rsum = (W3+2)'(d0_3_ff) + (W3+2)'(rx_ff);
   assign over = 64'(rsum) >= 64'(MAX_DOMAINS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= cell_i;
         e_ff[0]  <= (nx == '0) || (ny == '0) || (nz == '0);
         m1_ff    <= W2'(dy) * W2'(dom[2]);
         ynx_1_ff <= W2'(loc[1]) * W2'(nx);
         nxy_ff   <= W2'(nx) * W2'(ny);
         d0_1_ff  <= dom[0];
         d1_1_ff  <= dom[1];
         l0_1_ff  <= loc[0];
         l2_1_ff  <= loc[2];

         c2_ff    <= c1_ff;
         e_ff[1]  <= e_ff[0];
         t_ff     <= (W2+1)'(d1_1_ff) + (W2+1)'(m1_ff);
         zp_ff    <= W3'(l2_1_ff) * W3'(nxy_ff);
         ynx_2_ff <= ynx_1_ff;
         d0_2_ff  <= d0_1_ff;
         l0_2_ff  <= l0_1_ff;

         c3_ff    <= c2_ff;
         e_ff[2]  <= e_ff[1];
         rx_ff    <= (W3+1)'(W3'(dx) * W3'(t_ff));
         is_ff    <= (W3+1)'(l0_2_ff) + (W3+1)'(ynx_2_ff) + (W3+1)'(zp_ff);
         d0_3_ff  <= d0_2_ff;

         for (int a = 0; a < 3; a++) begin
            cell_o[a] <= pcb_pkg::CELL_OUT_BITS'(c3_ff[a]);
         end
         rank_ff <= over ? '0 : pcb_pkg::RANK_OUT_BITS'(rsum);
         idx_ff  <= (64'(is_ff) > 64'(pcb_pkg::IDX_MAX)) ? pcb_pkg::IDX_MAX
                                                         : pcb_pkg::IDX_BITS'(is_ff);
         err_ff  <= e_ff[2] || over;
      end
   end

   assign out_valid = v_ff[3];
   assign rank      = rank_ff;
   assign idx       = idx_ff;
   assign err       = err_ff;

endmodule

// File: hw/rtl/particle_cell_binning.sv
// ----------------------------------------------------------------------------
// particle_cell_binning
// Bins particle positions into global cells, owning domain and local index.
// Each result passes through the cell stage, the divider and the index stage in order.
// Throughput: one item per cycle; the pipeline holds as a whole while rsp_stall blocks it.
// The COUNT_BITS-stage divider sets the depth.
// Reset clears all valid bits and sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module particle_cell_binning #(
   parameter int COUNT_BITS  = 10,
   parameter int MAX_DOMAINS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_x,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_y,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_x,
   output logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_y,
   output logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_z,
   output logic [pcb_pkg::RANK_OUT_BITS-1:0]   rsp_domain_rank,
   output logic [pcb_pkg::IDX_BITS-1:0]        rsp_local_cell_index,
   output logic                                rsp_config_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcb_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [pcb_pkg::ROW_BITS-1:0]        csr_wdata
);

   localparam int CW = 3 * COUNT_BITS;
   localparam logic [CW-1:0] COUNTS_RESET = {3{COUNT_BITS'(1)}};

   logic [2:0][pcb_pkg::ROW_BITS-1:0] rows_ff;
   logic [CW-1:0]                     gcnt_ff, lcnt_ff, dcnt_ff;
   logic                              en;
   logic                              v_cell, v_div;
   logic [2:0][COUNT_BITS-1:0]        cell_a, cell_b, dom, loc;
   logic [2:0][pcb_pkg::CELL_OUT_BITS-1:0] cell_out;

   assign csr_ready = 1'b1;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         gcnt_ff <= COUNTS_RESET;
         lcnt_ff <= COUNTS_RESET;
         dcnt_ff <= COUNTS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (pcb_pkg::csr_addr_type'(csr_addr))
            pcb_pkg::CSR_ROW_A:   rows_ff[0] <= csr_wdata;
            pcb_pkg::CSR_ROW_B:   rows_ff[1] <= csr_wdata;
            pcb_pkg::CSR_ROW_C:   rows_ff[2] <= csr_wdata;
            pcb_pkg::CSR_GLOBAL:  gcnt_ff <= csr_wdata[CW-1:0];
            pcb_pkg::CSR_LOCAL:   lcnt_ff <= csr_wdata[CW-1:0];
            pcb_pkg::CSR_DOMAINS: dcnt_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   pcb_cell_stage #(.CB(COUNT_BITS)) u_cell (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .rows      (rows_ff),
      .gcounts   (gcnt_ff),
      .out_valid (v_cell),
      .cell_o    (cell_a)
   );

   pcb_divider #(.CB(COUNT_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_cell),
      .cell_i    (cell_a),
      .lcounts   (lcnt_ff),
      .out_valid (v_div),
      .cell_o    (cell_b),
      .dom       (dom),
      .loc       (loc)
   );

   pcb_index_stage #(.CB(COUNT_BITS), .MAX_DOMAINS(MAX_DOMAINS)) u_index (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_div),
      .cell_i    (cell_b),
      .dom       (dom),
      .loc       (loc),
      .lcounts   (lcnt_ff),
      .dcounts   (dcnt_ff),
      .out_valid (rsp_valid),
      .cell_o    (cell_out),
      .rank      (rsp_domain_rank),
      .idx       (rsp_local_cell_index),
      .err       (rsp_config_error)
   );

   assign rsp_cell_x = cell_out[0];
   assign rsp_cell_y = cell_out[1];
   assign rsp_cell_z = cell_out[2];

endmodule

// File: tb/particle_cell_binning_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_cell_binning_checker
// Watches the request, response and register channels of the binning block.
// Mirrors the registers and computes the cell, rank and local index of every
// accepted particle. Each response is compared field by field with the oldest
// pending bin.
// ----------------------------------------------------------------------------
module particle_cell_binning_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_x,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_y,
   input  logic signed [pcb_pkg::POS_BITS-1:0] req_pos_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_x,
   input  logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_y,
   input  logic [pcb_pkg::CELL_OUT_BITS-1:0]   rsp_cell_z,
   input  logic [pcb_pkg::RANK_OUT_BITS-1:0]   rsp_domain_rank,
   input  logic [pcb_pkg::IDX_BITS-1:0]        rsp_local_cell_index,
   input  logic                                rsp_config_error,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pcb_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [pcb_pkg::ROW_BITS-1:0]        csr_wdata,
   output int                                  errors,
   output int                                  pending,
   output int                                  bins_checked
);

   localparam int  CNT_W      = 10;
   localparam int  DOMAIN_MAX = 1024;
   localparam logic [29:0] COUNTS_RST = 30'h0010_0401;

   typedef struct packed {
      logic [pcb_pkg::CELL_OUT_BITS-1:0] cx;
      logic [pcb_pkg::CELL_OUT_BITS-1:0] cy;
      logic [pcb_pkg::CELL_OUT_BITS-1:0] cz;
      logic [pcb_pkg::RANK_OUT_BITS-1:0] rank;
      logic [pcb_pkg::IDX_BITS-1:0]      idx;
      logic                              err;
   } bin_type;

   logic [pcb_pkg::ROW_BITS-1:0] row_q [3];
   logic [29:0]         global_q;
   logic [29:0]         local_q;
   logic [29:0]         domains_q;
   bin_type             bins_q [$];

   function automatic longint axis_cell(logic [pcb_pkg::ROW_BITS-1:0] row, longint px,
                                        longint py, longint pz, longint count);
      longint s;
      longint c0;
      longint c1;
      longint c2;
      longint v;
      c0 = $signed(row[20:0]);
      c1 = $signed(row[41:21]);
      c2 = $signed(row[62:42]);
      s = px * c0 + py * c1 + pz * c2;
      if (count == 0 || s <= 0) return 0;
      if ((s >>> pcb_pkg::FRAC_SHIFT) != 0) return count - 1;
      v = (count * (s & ((longint'(1) << pcb_pkg::FRAC_SHIFT) - 1))) >>> pcb_pkg::FRAC_SHIFT;
      if (v >= count) v = count - 1;
      return v;
   endfunction

   function automatic bin_type bin_particle(longint px, longint py, longint pz);
      longint cel [3];
      longint dom [3];
      longint loc [3];
      longint n [3];
      longint rank;
      longint idx;
      bin_type r;
      r.err = 1'b0;
      for (int k = 0; k < 3; k++) begin
         cel[k] = axis_cell(row_q[k], px, py, pz, longint'(global_q[k*CNT_W +: CNT_W]));
         n[k] = longint'(local_q[k*CNT_W +: CNT_W]);
         if (n[k] == 0) begin
            dom[k] = 0;
            r.err  = 1'b1;
         end else begin
            dom[k] = cel[k] / n[k];
         end
         loc[k] = cel[k] - dom[k] * n[k];
      end
      rank = dom[0] + longint'(domains_q[9:0]) *
             (dom[1] + longint'(domains_q[19:10]) * dom[2]);
      if (rank >= DOMAIN_MAX) begin
         rank  = 0;
         r.err = 1'b1;
      end
      idx = loc[0] + loc[1] * n[0] + loc[2] * n[0] * n[1];
      if (idx > longint'(pcb_pkg::IDX_MAX)) idx = longint'(pcb_pkg::IDX_MAX);
      r.cx   = cel[0][pcb_pkg::CELL_OUT_BITS-1:0];
      r.cy   = cel[1][pcb_pkg::CELL_OUT_BITS-1:0];
      r.cz   = cel[2][pcb_pkg::CELL_OUT_BITS-1:0];
      r.rank = rank[pcb_pkg::RANK_OUT_BITS-1:0];
      r.idx  = idx[pcb_pkg::IDX_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      bin_type got;
      bin_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) row_q[k] = '0;
         global_q  = COUNTS_RST;
         local_q   = COUNTS_RST;
         domains_q = COUNTS_RST;
         bins_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_cell_x, rsp_cell_y, rsp_cell_z, rsp_domain_rank,
                    rsp_local_cell_index, rsp_config_error};
            if (bins_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response: %p", got);
            end else begin
               want = bins_q.pop_front();
               bins_checked++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_valid && !req_stall)
            bins_q.insert(bins_q.size(),
                          bin_particle(longint'(req_pos_x), longint'(req_pos_y),
                                       longint'(req_pos_z)));
         if (csr_valid && csr_ready) begin
            unique case (pcb_pkg::csr_addr_type'(csr_addr))
               pcb_pkg::CSR_ROW_A:   row_q[0]  = csr_wdata;
               pcb_pkg::CSR_ROW_B:   row_q[1]  = csr_wdata;
               pcb_pkg::CSR_ROW_C:   row_q[2]  = csr_wdata;
               pcb_pkg::CSR_GLOBAL:  global_q  = csr_wdata[29:0];
               pcb_pkg::CSR_LOCAL:   local_q   = csr_wdata[29:0];
               pcb_pkg::CSR_DOMAINS: domains_q = csr_wdata[29:0];
               default: ;
            endcase
         end
      end
      pending = bins_q.size();
   end

   initial begin
      errors       = 0;
      pending      = 0;
      bins_checked = 0;
   end

endmodule

// File: tb/particle_cell_binning_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_cell_binning_tb
// Drives particle positions and register settings into the binning block.
// Runs several box and decomposition settings, extremes included, with
// directed corner positions and random streams under varying backpressure.
// ----------------------------------------------------------------------------
module particle_cell_binning_tb;

   localparam int LIMIT  = 400000;
   localparam int SETTLE = 40;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [pcb_pkg::POS_BITS-1:0]  req_pos_x;
   logic signed [pcb_pkg::POS_BITS-1:0]  req_pos_y;
   logic signed [pcb_pkg::POS_BITS-1:0]  req_pos_z;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [pcb_pkg::CELL_OUT_BITS-1:0]    rsp_cell_x;
   logic [pcb_pkg::CELL_OUT_BITS-1:0]    rsp_cell_y;
   logic [pcb_pkg::CELL_OUT_BITS-1:0]    rsp_cell_z;
   logic [pcb_pkg::RANK_OUT_BITS-1:0]    rsp_domain_rank;
   logic [pcb_pkg::IDX_BITS-1:0]         rsp_local_cell_index;
   logic                                 rsp_config_error;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [pcb_pkg::CSR_ADDR_BITS-1:0]    csr_addr;
   logic [pcb_pkg::ROW_BITS-1:0]         csr_wdata;
   int                                   errors;
   int                                   pending;
   int                                   bins_checked;
   int                                   cycles;
   int                                   send_idle;
   int                                   recv_idle;
   int                                   particles;

   particle_cell_binning i_dut (.*);

   particle_cell_binning_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (cycles > LIMIT) begin
         $display("particle_cell_binning regression: fail");
         $finish;
      end
   end

   function automatic logic [pcb_pkg::ROW_BITS-1:0] pack_coefs(int cx, int cy, int cz);
      logic [20:0] a;
      logic [20:0] b;
      logic [20:0] c;
      a = cx[20:0];
      b = cy[20:0];
      c = cz[20:0];
      return {c, b, a};
   endfunction

   function automatic logic [pcb_pkg::ROW_BITS-1:0] pack_counts(int nx, int ny, int nz);
      return pcb_pkg::ROW_BITS'({nz[9:0], ny[9:0], nx[9:0]});
   endfunction

   function automatic logic [pcb_pkg::ROW_BITS-1:0] rand_row();
      return pcb_pkg::ROW_BITS'({$urandom, $urandom});
   endfunction

   task automatic write_reg(pcb_pkg::csr_addr_type addr, logic [pcb_pkg::ROW_BITS-1:0] data);
      bit done;
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      done = 0;
      while (!done) begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end
   endtask

   task automatic setup_box(logic [pcb_pkg::ROW_BITS-1:0] ra, logic [pcb_pkg::ROW_BITS-1:0] rb,
                            logic [pcb_pkg::ROW_BITS-1:0] rc, logic [pcb_pkg::ROW_BITS-1:0] g,
                            logic [pcb_pkg::ROW_BITS-1:0] l, logic [pcb_pkg::ROW_BITS-1:0] d);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(pcb_pkg::CSR_ROW_A, ra);
      write_reg(pcb_pkg::CSR_ROW_B, rb);
      write_reg(pcb_pkg::CSR_ROW_C, rc);
      write_reg(pcb_pkg::CSR_GLOBAL, g);
      write_reg(pcb_pkg::CSR_LOCAL, l);
      write_reg(pcb_pkg::CSR_DOMAINS, d);
      csr_valid <= 1'b0;
   endtask

   task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      bit done;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      done = 0;
      while (!done) begin
         @(negedge clock);
         done = !req_stall;
         @(posedge clock);
      end
      particles++;
   endtask

   function automatic logic [31:0] rand_pos(int span);
      unique case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom_range(span) - span / 8;
      endcase
   endfunction

   task automatic run_particles(int n, int span);
      logic [31:0] corners [8];
      corners = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff,
                  32'h0001_0000, 32'h0000_8000, 32'h003f_ffff};
      for (int i = 0; i < 8; i++) send_particle(corners[i], corners[7 - i], corners[i]);
      send_particle(corners[1], corners[1], corners[1]);
      send_particle(corners[2], corners[2], corners[2]);
      for (int i = 0; i < n; i++)
         send_particle(rand_pos(span), rand_pos(span), rand_pos(span));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      cycles    = 0;
      particles = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      send_idle = 29;
      recv_idle = 46;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero matrix puts everything in cell 0
      run_particles(20, 32'h0100_0000);

      setup_box(pack_coefs(1 << 14, 0, 0), pack_coefs(0, 1 << 14, 0),
                pack_coefs(0, 0, 1 << 14), pack_counts(16, 8, 4),
                pack_counts(4, 4, 2), pack_counts(4, 2, 2));
      run_particles(140, 64 << 16);

      send_idle = 46;
      recv_idle = 29;
      setup_box(pack_coefs(20'hfffff, -(1 << 20), 1234), pack_coefs(-1, 1 << 19, 1 << 15),
                pack_coefs(1 << 12, -(1 << 13), 20'hfffff), pack_counts(1023, 1023, 1023),
                pack_counts(1, 1, 1), pack_counts(1023, 1023, 1023));
      run_particles(110, 2 << 16);

      setup_box(rand_row(), rand_row(), rand_row(),
                pack_counts(0, 37, 1000), pack_counts(0, 5, 0), pack_counts(3, 0, 7));
      run_particles(110, 256 << 16);

      send_idle = 0;
      recv_idle = 0;
      setup_box(pack_coefs(1 << 15, 1 << 10, 0), pack_coefs(0, 1 << 15, -(1 << 9)),
                pack_coefs(1 << 8, 0, 1 << 15), pack_counts(1023, 600, 900),
                pack_counts(1023, 1023, 1023), pack_counts(1, 1, 1));
      run_particles(110, 32 << 16);

      setup_box(rand_row(), rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
      run_particles(110, 128 << 16);

      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("binned %0d particles, %0d responses checked, over six register settings",
               particles, bins_checked);
      $display("settings covered reset values, unit and extreme counts, zero counts, rank overflow");
      if (errors == 0) begin
         $display("particle_cell_binning regression: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("particle_cell_binning regression: fail");
      end
      $finish;
   end

endmodule

// File: particle_cell_binning.f
hw/rtl/pcb_pkg.sv
hw/rtl/pcb_cell_stage.sv
hw/rtl/pcb_divider.sv
hw/rtl/pcb_index_stage.sv
hw/rtl/particle_cell_binning.sv
tb/particle_cell_binning_checker.sv
tb/particle_cell_binning_tb.sv
